FILE: src/scs1_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scs1_pkg
// Shared types, scancode constants and keymaps for the set-1 translator.
// ----------------------------------------------------------------------------
package scs1_pkg;

   // Input word and result word
   typedef struct packed {
      logic [7:0] scan_byte;
      logic       aux_flag;
   } req_type;

   typedef struct packed {
      logic       out_kind;
      logic [7:0] out_byte;
      logic [2:0] led_bits;
      logic       last;
   } rsp_type;

   // Command from the front end: up to four bytes, or one LED update
   typedef struct packed {
      logic            kind;
      logic [2:0]      leds;
      logic [1:0]      len_m1;
      logic [3:0][7:0] bytes;
   } cmd_type;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_LED  = 1'b1;

   localparam logic [2:0] LED_SCROLL = 3'b001;
   localparam logic [2:0] LED_CAPS   = 3'b010;
   localparam logic [2:0] LED_NUM    = 3'b100;

   localparam logic [7:0] SC_PREFIX   = 8'he0;
   localparam logic [7:0] SC_CTRL     = 8'h1d;
   localparam logic [7:0] SC_CTRL_REL = 8'h9d;
   localparam logic [7:0] SC_LSHIFT   = 8'h2a;
   localparam logic [7:0] SC_RSHIFT   = 8'h36;
   localparam logic [7:0] SC_CAPS     = 8'h3a;
   localparam logic [7:0] SC_NUM      = 8'h45;
   localparam logic [7:0] SC_SCROLL   = 8'h46;
   localparam logic [7:0] SC_KP_ENTER = 8'h1c;
   localparam logic [7:0] SC_KP_SLASH = 8'h35;
   localparam logic [7:0] SC_UP       = 8'h48;
   localparam logic [7:0] SC_DOWN     = 8'h50;
   localparam logic [7:0] SC_RIGHT    = 8'h4d;
   localparam logic [7:0] SC_LEFT     = 8'h4b;
   localparam logic [7:0] SC_HOME     = 8'h47;
   localparam logic [7:0] SC_END      = 8'h4f;
   localparam logic [7:0] SC_DELETE   = 8'h53;
   localparam logic [7:0] SC_PGUP     = 8'h49;
   localparam logic [7:0] SC_PGDN     = 8'h51;

   localparam logic [7:0] CH_ESC   = 8'h1b;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CSI   = 8'h5b;  // '['
   localparam logic [7:0] CH_SS3   = 8'h4f;  // 'O'
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_TILDE = 8'h7e;

   localparam int unsigned MAP_LEN = 58;

   localparam logic [7:0] MAP_PLAIN [0:MAP_LEN-1] = '{
      8'h00, 8'h1b, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h3d, 8'h7f, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0d, 8'h00, 8'h61, 8'h73,
      8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b,
      8'h27, 8'h60, 8'h00, 8'h5c, 8'h7a, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6e, 8'h6d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h00,
      8'h00, 8'h20
   };

   localparam logic [7:0] MAP_SHIFT [0:MAP_LEN-1] = '{
      8'h00, 8'h1b, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e,
      8'h26, 8'h2a, 8'h28, 8'h29, 8'h5f, 8'h2b, 8'h7f, 8'h09,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h0d, 8'h00, 8'h41, 8'h53,
      8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a,
      8'h22, 8'h7e, 8'h00, 8'h7c, 8'h5a, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h00,
      8'h00, 8'h20
   };

   localparam logic [7:0] MAP_CTRL [0:MAP_LEN-1] = '{
      8'h00, 8'h1b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h09,
      8'h11, 8'h17, 8'h05, 8'h12, 8'h14, 8'h19, 8'h15, 8'h09,
      8'h0f, 8'h10, 8'h00, 8'h00, 8'h0a, 8'h00, 8'h01, 8'h13,
      8'h04, 8'h06, 8'h07, 8'h08, 8'h0a, 8'h0b, 8'h0c, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h1a, 8'h18, 8'h03, 8'h16,
      8'h02, 8'h0e, 8'h0d, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h20
   };

   // Character for a make code under the current modifiers; 0 means none
   function automatic logic [7:0] key_lookup(input logic [7:0] code,
                                             input logic       ctrl,
                                             input logic       shift,
                                             input logic       caps);
      logic [5:0] idx;
      logic [7:0] c;
      idx = code[5:0];
      c   = 8'h00;
      if (code < 8'(MAP_LEN)) begin
         if (ctrl) begin
            c = MAP_CTRL[idx];
         end else begin
            c = shift ? MAP_SHIFT[idx] : MAP_PLAIN[idx];
            if (caps && (((c >= 8'h61) && (c <= 8'h7a)) ||
                         ((c >= 8'h41) && (c <= 8'h5a)))) begin
               c = c ^ 8'h20;
            end
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: src/scs1_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scs1_front
// Accepts scancode words, tracks modifier, prefix and LED state, and turns
// each word that produces output into one command for the back end.
// ----------------------------------------------------------------------------
module scs1_front
   import scs1_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire req_type req,
   input  wire logic    cursor_app_mode,
   input  wire logic    text_enable,
   output logic         cmd_push,
   output cmd_type      cmd
);

   logic       shift_held_ff, shift_held_in;
   logic       ctrl_held_ff,  ctrl_held_in;
   logic       caps_on_ff,    caps_on_in;
   logic       prefix_seen_ff, prefix_seen_in;
   logic [2:0] lock_leds_ff,  lock_leds_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_held_ff  <= 1'b0;
         ctrl_held_ff   <= 1'b0;
         caps_on_ff     <= 1'b0;
         prefix_seen_ff <= 1'b0;
         lock_leds_ff   <= 3'b000;
      end else begin
         shift_held_ff  <= shift_held_in;
         ctrl_held_ff   <= ctrl_held_in;
         caps_on_ff     <= caps_on_in;
         prefix_seen_ff <= prefix_seen_in;
         lock_leds_ff   <= lock_leds_in;
      end
   end

   always_comb begin
      logic [7:0] sb;
      logic [7:0] code;
      logic       rel;
      logic       plain;
      logic [7:0] c;
      logic [7:0] mid;
      logic [2:0] leds;

      sb   = req.scan_byte;
      code = {1'b0, sb[6:0]};
      rel  = sb[7];
      plain = 1'b0;
      c    = 8'h00;
      mid  = cursor_app_mode ? CH_SS3 : CH_CSI;
      leds = lock_leds_ff;

      shift_held_in  = shift_held_ff;
      ctrl_held_in   = ctrl_held_ff;
      caps_on_in     = caps_on_ff;
      prefix_seen_in = prefix_seen_ff;
      lock_leds_in   = lock_leds_ff;
      cmd_push       = 1'b0;
      cmd            = '0;
      cmd.kind       = KIND_CHAR;
      cmd.bytes[0]   = CH_ESC;

      if (accept && !req.aux_flag) begin
         if (sb == SC_PREFIX) begin
            prefix_seen_in = 1'b1;
         end else begin
            prefix_seen_in = 1'b0;
            plain          = 1'b1;
            if (prefix_seen_ff) begin
               plain = 1'b0;
               case (sb)
                  SC_CTRL:     ctrl_held_in = 1'b1;
                  SC_CTRL_REL: ctrl_held_in = 1'b0;
                  SC_KP_ENTER: begin
                     cmd_push     = 1'b1;
                     cmd.bytes[0] = CH_LF;
                  end
                  SC_KP_SLASH: begin
                     cmd_push     = 1'b1;
                     cmd.bytes[0] = CH_SLASH;
                  end
                  SC_UP, SC_DOWN, SC_RIGHT, SC_LEFT: begin
                     cmd_push     = 1'b1;
                     cmd.len_m1   = 2'd2;
                     cmd.bytes[1] = mid;
                     case (sb)
                        SC_UP:    cmd.bytes[2] = 8'h41;
                        SC_DOWN:  cmd.bytes[2] = 8'h42;
                        SC_RIGHT: cmd.bytes[2] = 8'h43;
                        default:  cmd.bytes[2] = 8'h44;
                     endcase
                  end
                  SC_HOME, SC_END, SC_DELETE, SC_PGUP, SC_PGDN: begin
                     cmd_push     = 1'b1;
                     cmd.len_m1   = 2'd3;
                     cmd.bytes[1] = CH_CSI;
                     cmd.bytes[3] = CH_TILDE;
                     case (sb)
                        SC_HOME:   cmd.bytes[2] = 8'h31;
                        SC_END:    cmd.bytes[2] = 8'h34;
                        SC_DELETE: cmd.bytes[2] = 8'h33;
                        SC_PGUP:   cmd.bytes[2] = 8'h35;
                        default:   cmd.bytes[2] = 8'h36;
                     endcase
                  end
                  default: plain = 1'b1;
               endcase
            end

            if (plain) begin
               if (code == SC_CTRL) begin
                  ctrl_held_in = !rel;
               end else if (code inside {SC_LSHIFT, SC_RSHIFT}) begin
                  shift_held_in = !rel;
               end else if ((code == SC_CAPS) && !rel) begin
                  caps_on_in = !caps_on_ff;
               end else if (!rel) begin
                  c = key_lookup(code, ctrl_held_ff, shift_held_ff, caps_on_ff);
               end

               case (sb)
                  SC_CAPS:   leds = lock_leds_ff ^ LED_CAPS;
                  SC_NUM:    leds = lock_leds_ff ^ LED_NUM;
                  SC_SCROLL: leds = lock_leds_ff ^ LED_SCROLL;
                  default:   leds = lock_leds_ff;
               endcase

               // Lock keys never map to a character, so one result at most
               if (leds != lock_leds_ff) begin
                  lock_leds_in = leds;
                  cmd_push     = 1'b1;
                  cmd.kind     = KIND_LED;
                  cmd.leds     = leds;
                  cmd.bytes[0] = 8'h00;
               end else if (text_enable && (c != 8'h00)) begin
                  cmd_push     = 1'b1;
                  cmd.bytes[0] = c;
               end
            end
         end
      end
   end

endmodule
`default_nettype wire

FILE: src/scs1_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scs1_queue
// Small command queue between the front and back ends.
// ----------------------------------------------------------------------------
module scs1_queue
   import scs1_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   input  wire logic    pop,
   output cmd_type      pop_data,
   output logic         full,
   output logic         empty
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: src/scs1_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scs1_back
// Expands queued commands into result words, one per cycle, into an output
// register that holds while the consumer stalls.
// ----------------------------------------------------------------------------
module scs1_back
   import scs1_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   input  wire logic    cmd_empty,
   output logic         cmd_pop,
   output rsp_type      rsp_data,
   output logic         rsp_empty,
   input  wire logic    rsp_pop
);

   logic [1:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;
   logic       load, take, at_end;

   assign load    = !out_valid_ff || rsp_pop;
   assign take    = load && !cmd_empty;
   assign at_end  = (idx_ff == cmd.len_m1);
   assign cmd_pop = take && at_end;

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = load ? take : out_valid_ff;
      out_in       = out_ff;
      if (take) begin
         // advance through the command's bytes, drop it after the last one
         idx_in          = at_end ? 2'd0 : idx_ff + 2'd1;
         out_in.out_kind = cmd.kind;
         out_in.last     = at_end;
         if (cmd.kind == KIND_LED) begin
            out_in.out_byte = 8'h00;
            out_in.led_bits = cmd.leds;
         end else begin
            out_in.out_byte = cmd.bytes[idx_ff];
            out_in.led_bits = 3'b000;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_data  = out_ff;
   assign rsp_empty = !out_valid_ff;

`ifndef NO_ASSERTIONS
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      !cmd_empty |-> (idx_ff <= cmd.len_m1))
      else $error("byte index past end of command");

   a_idx_idle_zero: assert property (@(posedge clock) disable iff (reset)
      cmd_empty |-> (idx_ff == 2'd0))
      else $error("byte index not rewound with no command pending");

   a_led_single: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.out_kind == KIND_LED)) |-> (out_ff.last && out_ff.out_byte == 8'h00))
      else $error("LED word must be a lone word with zero byte");

   a_char_no_leds: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.out_kind == KIND_CHAR)) |-> (out_ff.led_bits == 3'b000))
      else $error("character word carries LED bits");
`endif

endmodule
`default_nettype wire

FILE: src/scancode_set1_to_ascii.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scancode_set1_to_ascii
// PS/2 set-1 scancode to terminal character translator with lock LEDs.
// ----------------------------------------------------------------------------
// The front end takes one scancode word per cycle whenever the command queue
// (QUEUE_DEPTH entries) has room, updates the modifier, E0-prefix and LED
// state in that cycle, and queues one command for every word that yields
// output. The back end turns a command into 1 to 4 result words, one word per
// cycle while the consumer does not stall: a character or LED update is one
// word, an arrow key three and Home/End/Delete/PageUp/PageDown four, so the
// back end's byte sequencer sets the sustained rate. Words that yield nothing
// (prefix, modifiers, releases, aux bytes) are not queued. A command is
// registered in the queue before the back end loads its output register.
// ----------------------------------------------------------------------------
module scancode_set1_to_ascii
   import scs1_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire req_type     req_data,
   output logic             req_full,
   output rsp_type          rsp_data,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic REG_CURSOR_MODE = 1'b0;
   localparam logic REG_TEXT_ENABLE = 1'b1;

   logic    cursor_app_mode_ff, cursor_app_mode_in;
   logic    text_enable_ff,     text_enable_in;
   logic    csr_write;
   logic    accept;
   logic    cmd_push, cmd_pop, q_full, q_empty;
   cmd_type cmd_in, cmd_out;

   // Register file
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cursor_app_mode_in = cursor_app_mode_ff;
      text_enable_in     = text_enable_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_CURSOR_MODE: cursor_app_mode_in = csr_pwdata[0];
            REG_TEXT_ENABLE: text_enable_in     = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_app_mode_ff <= 1'b0;
         text_enable_ff     <= 1'b1;
      end else begin
         cursor_app_mode_ff <= cursor_app_mode_in;
         text_enable_ff     <= text_enable_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_CURSOR_MODE: csr_prdata = {31'd0, cursor_app_mode_ff};
         REG_TEXT_ENABLE: csr_prdata = {31'd0, text_enable_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   scs1_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req             (req_data),
      .cursor_app_mode (cursor_app_mode_ff),
      .text_enable     (text_enable_ff),
      .cmd_push        (cmd_push),
      .cmd             (cmd_in)
   );

   scs1_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .full      (q_full),
      .empty     (q_empty)
   );

   scs1_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd_out),
      .cmd_empty (q_empty),
      .cmd_pop   (cmd_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

endmodule
`default_nettype wire
